/* rtl/core/simd_register_reorder_unit_macros.svh */
`ifndef SIMD_REGISTER_REORDER_UNIT_MACROS_SVH
`define SIMD_REGISTER_REORDER_UNIT_MACROS_SVH

// same-cycle implication under reset
`define SRRU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srru assertion failed");

// next-cycle implication under reset
`define SRRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srru assertion failed");

`endif

/* rtl/core/srru_pkg.sv */
package srru_pkg;

    localparam int DWORD_W = 64;
    localparam int QWORD_W = 2 * DWORD_W;
    localparam int ACTION_W = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PCPYH  = 5'd0,
        ACT_PCPYLD = 5'd1,
        ACT_PCPYUD = 5'd2,
        ACT_PEXCH  = 5'd3,
        ACT_PEXCW  = 5'd4,
        ACT_PEXEH  = 5'd5,
        ACT_PEXEW  = 5'd6,
        ACT_PEXTLB = 5'd7,
        ACT_PEXTLH = 5'd8,
        ACT_PEXTLW = 5'd9,
        ACT_PEXTUB = 5'd10,
        ACT_PEXTUH = 5'd11,
        ACT_PEXTUW = 5'd12,
        ACT_PINTEH = 5'd13,
        ACT_PINTH  = 5'd14,
        ACT_PPACB  = 5'd15,
        ACT_PPACH  = 5'd16,
        ACT_PPACW  = 5'd17,
        ACT_PREVH  = 5'd18,
        ACT_PROT3W = 5'd19
    } action_t;

    // 4-lane maps, source lane for destination lane k at bits 2k+1:2k
    typedef logic [7:0] lane_map_t;

    localparam lane_map_t MAP_EXC = {2'd3, 2'd1, 2'd2, 2'd0};
    localparam lane_map_t MAP_EXE = {2'd3, 2'd0, 2'd1, 2'd2};
    localparam lane_map_t MAP_REV = {2'd0, 2'd1, 2'd2, 2'd3};
    localparam lane_map_t MAP_ROT = {2'd3, 2'd0, 2'd2, 2'd1};

endpackage

/* rtl/core/simd_register_reorder_unit.sv */
// Stages: input register, then result register, before out_valid rises.
// Throughput: one transaction per cycle unless out_ready stalls; the permute network
// is pure muxing between the two registers; a stalled output backs up one stage at a time.
// Reset (rst_n low, asynchronous): both stage valid flags clear; data registers
// are not reset.
`include "simd_register_reorder_unit_macros.svh"

module simd_register_reorder_unit
    import srru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ACTION_W-1:0]  action,
    input  logic [DWORD_W-1:0]   rs_low,
    input  logic [DWORD_W-1:0]   rs_high,
    input  logic [DWORD_W-1:0]   rt_low,
    input  logic [DWORD_W-1:0]   rt_high,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DWORD_W-1:0]   rd_low,
    output logic [DWORD_W-1:0]   rd_high
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [ACTION_W-1:0]  action_reg;
    logic [QWORD_W-1:0]   rs_reg;
    logic [QWORD_W-1:0]   rt_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [QWORD_W-1:0]   rd_reg;
    logic [QWORD_W-1:0]   rd_next;
    logic                 out_free;
    logic                 s1_ready;
    logic                 in_fire;
    logic                 s1_fire;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && s1_ready;
    assign s1_fire  = s1_valid_reg && out_free;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !out_free);
    assign out_valid_next = s1_fire || (out_valid_reg && !out_ready);

    srru_permute u_permute (
        .action (action_t'(action_reg)),
        .rs     (rs_reg),
        .rt     (rt_reg),
        .rd     (rd_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= action;
            rs_reg     <= {rs_high, rs_low};
            rt_reg     <= {rt_high, rt_low};
        end
        if (s1_fire)
        begin
            rd_reg <= rd_next;
        end
    end

    assign in_ready  = s1_ready;
    assign out_valid = out_valid_reg;
    assign rd_low    = rd_reg[DWORD_W-1:0];
    assign rd_high   = rd_reg[QWORD_W-1:DWORD_W];

    `SRRU_ASSERT_NEXT(a_in_loads_s1, clk, rst_n, in_fire, s1_valid_reg)
    `SRRU_ASSERT_NEXT(a_s1_moves_out, clk, rst_n, s1_fire, out_valid_reg)
    `SRRU_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !out_free,
        s1_valid_reg && $stable(action_reg) && $stable(rs_reg) && $stable(rt_reg))
    `SRRU_ASSERT_NEXT(a_pcpyld_result, clk, rst_n,
        s1_fire && (action_reg == ACT_PCPYLD),
        rd_reg == {$past(rs_reg[DWORD_W-1:0]), $past(rt_reg[DWORD_W-1:0])})
    `SRRU_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !s1_valid_reg, in_ready)

endmodule

/* rtl/core/srru_permute.sv */
module srru_permute
    import srru_pkg::*;
(
    input  action_t              action,
    input  logic [QWORD_W-1:0]   rs,
    input  logic [QWORD_W-1:0]   rt,
    output logic [QWORD_W-1:0]   rd
);

    function automatic logic [QWORD_W-1:0] ilv_b(logic [QWORD_W-1:0] s,
                                                 logic [QWORD_W-1:0] t, int base);
        logic [QWORD_W-1:0] d;
        d = '0;
        for (int i = 0; i < 8; i++)
        begin
            d[16*i +: 8]     = t[8*(i+base) +: 8];
            d[16*i + 8 +: 8] = s[8*(i+base) +: 8];
        end
        return d;
    endfunction

    function automatic logic [QWORD_W-1:0] ilv_h(logic [QWORD_W-1:0] s,
                                                 logic [QWORD_W-1:0] t, int base);
        logic [QWORD_W-1:0] d;
        d = '0;
        for (int i = 0; i < 4; i++)
        begin
            d[32*i +: 16]      = t[16*(i+base) +: 16];
            d[32*i + 16 +: 16] = s[16*(i+base) +: 16];
        end
        return d;
    endfunction

    function automatic logic [QWORD_W-1:0] ilv_w(logic [QWORD_W-1:0] s,
                                                 logic [QWORD_W-1:0] t, int base);
        logic [QWORD_W-1:0] d;
        d = '0;
        for (int i = 0; i < 2; i++)
        begin
            d[64*i +: 32]      = t[32*(i+base) +: 32];
            d[64*i + 32 +: 32] = s[32*(i+base) +: 32];
        end
        return d;
    endfunction

    function automatic logic [QWORD_W-1:0] pack_b(logic [QWORD_W-1:0] s,
                                                  logic [QWORD_W-1:0] t);
        logic [QWORD_W-1:0] d;
        d = '0;
        for (int i = 0; i < 8; i++)
        begin
            d[8*i +: 8]     = t[16*i +: 8];
            d[8*(i+8) +: 8] = s[16*i +: 8];
        end
        return d;
    endfunction

    function automatic logic [QWORD_W-1:0] pack_h(logic [QWORD_W-1:0] s,
                                                  logic [QWORD_W-1:0] t);
        logic [QWORD_W-1:0] d;
        d = '0;
        for (int i = 0; i < 4; i++)
        begin
            d[16*i +: 16]     = t[32*i +: 16];
            d[16*(i+4) +: 16] = s[32*i +: 16];
        end
        return d;
    endfunction

    function automatic logic [QWORD_W-1:0] pack_w(logic [QWORD_W-1:0] s,
                                                  logic [QWORD_W-1:0] t);
        logic [QWORD_W-1:0] d;
        d = '0;
        for (int i = 0; i < 2; i++)
        begin
            d[32*i +: 32]     = t[64*i +: 32];
            d[32*(i+2) +: 32] = s[64*i +: 32];
        end
        return d;
    endfunction

    // halfword map applied to each doubleword
    function automatic logic [QWORD_W-1:0] map_h(logic [QWORD_W-1:0] t, lane_map_t m);
        logic [QWORD_W-1:0] d;
        d = '0;
        for (int g = 0; g < 2; g++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                d[16*(4*g+k) +: 16] = t[16*(4*g + int'(m[2*k +: 2])) +: 16];
            end
        end
        return d;
    endfunction

    function automatic logic [QWORD_W-1:0] map_w(logic [QWORD_W-1:0] t, lane_map_t m);
        logic [QWORD_W-1:0] d;
        d = '0;
        for (int k = 0; k < 4; k++)
        begin
            d[32*k +: 32] = t[32*int'(m[2*k +: 2]) +: 32];
        end
        return d;
    endfunction

    always_comb
    begin
        rd = '0;
        case (action)
            ACT_PCPYH:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rd[16*i +: 16]     = rt[15:0];
                    rd[16*(i+4) +: 16] = rt[79:64];
                end
            end
            ACT_PCPYLD: rd = {rs[DWORD_W-1:0], rt[DWORD_W-1:0]};
            ACT_PCPYUD: rd = {rt[QWORD_W-1:DWORD_W], rs[QWORD_W-1:DWORD_W]};
            ACT_PEXCH:  rd = map_h(rt, MAP_EXC);
            ACT_PEXCW:  rd = map_w(rt, MAP_EXC);
            ACT_PEXEH:  rd = map_h(rt, MAP_EXE);
            ACT_PEXEW:  rd = map_w(rt, MAP_EXE);
            ACT_PEXTLB: rd = ilv_b(rs, rt, 0);
            ACT_PEXTLH: rd = ilv_h(rs, rt, 0);
            ACT_PEXTLW: rd = ilv_w(rs, rt, 0);
            ACT_PEXTUB: rd = ilv_b(rs, rt, 8);
            ACT_PEXTUH: rd = ilv_h(rs, rt, 4);
            ACT_PEXTUW: rd = ilv_w(rs, rt, 2);
            ACT_PINTEH:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rd[32*i +: 16]      = rt[32*i +: 16];
                    rd[32*i + 16 +: 16] = rs[32*i +: 16];
                end
            end
            ACT_PINTH:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rd[32*i +: 16]      = rt[16*i +: 16];
                    rd[32*i + 16 +: 16] = rs[16*(i+4) +: 16];
                end
            end
            ACT_PPACB:  rd = pack_b(rs, rt);
            ACT_PPACH:  rd = pack_h(rs, rt);
            ACT_PPACW:  rd = pack_w(rs, rt);
            ACT_PREVH:  rd = map_h(rt, MAP_REV);
            ACT_PROT3W: rd = map_w(rt, MAP_ROT);
            default:    rd = '0;
        endcase
    end

endmodule
